// ===== sv/hangul_jamo_glyph_selector_macros.svh =====
// Assertion macros shared by the glyph selector RTL
`ifndef HANGUL_JAMO_GLYPH_SELECTOR_MACROS_SVH
`define HANGUL_JAMO_GLYPH_SELECTOR_MACROS_SVH
// check a consequence in the next cycle
`define HJGS_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);
// check a consequence in the same cycle
`define HJGS_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);
`endif

// ===== sv/hjgs_pkg.sv =====
// Types, tables and glyph selection functions for the glyph selector
package hjgs_pkg;

    typedef struct packed {
        logic [4:0] initial_index;
        logic [4:0] vowel_index;
        logic [4:0] final_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0] font_set;
        logic [7:0] initial_glyph;
        logic [7:0] vowel_glyph;
        logic [7:0] final_glyph;
        logic [1:0] glyph_count;
        logic       index_invalid;
    } out_item_t;

    localparam logic [4:0] INIT_MAX  = 5'd19;
    localparam logic [4:0] VOWEL_MAX = 5'd21;
    localparam logic [4:0] FINAL_MAX = 5'd27;
    localparam logic [4:0] IDX_H     = 5'd19;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;
    localparam logic [31:0] KGRP = 32'h0001_0006;
    localparam logic [31:0] DGRP = 32'h0000_4A24;

    localparam logic [21:0] SET2_MASK = 22'b01_0011_1001_1101_0101_0100;

    localparam logic [7:0] INIT_GLYPHS [15][20] = '{
      '{8'h00,8'h10,8'h11,8'h12,8'h14,8'h16,8'h18,8'h1a,8'h1b,8'h1c,
        8'h1d,8'h1e,8'h1f,8'h0f,8'h21,8'h22,8'h23,8'h24,8'h26,8'h28},
      '{8'h00,8'h10,8'h11,8'h13,8'h15,8'h17,8'h19,8'h1a,8'h1b,8'h1c,
        8'h1d,8'h1e,8'h1f,8'h0f,8'h21,8'h22,8'h23,8'h25,8'h27,8'h28},
      '{8'h00,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h3b,8'h3c,
        8'h3d,8'h3e,8'h3f,8'h40,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46},
      '{8'h00,8'h4f,8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
        8'h58,8'h59,8'h5a,8'h5b,8'h5c,8'h5d,8'h5e,8'h5f,8'h60,8'h61},
      '{8'h00,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h3b,8'h3c,8'h3d,
        8'h3e,8'h3f,8'h40,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47},
      '{8'h00,8'h50,8'h51,8'h37,8'h52,8'h53,8'h3a,8'h3b,8'h54,8'h3d,
        8'h55,8'h56,8'h57,8'h58,8'h59,8'h43,8'h5a,8'h5b,8'h46,8'h5c},
      '{8'h00,8'h60,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h3d,
        8'h68,8'h69,8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,8'h6f,8'h70,8'h71},
      '{8'h00,8'h78,8'h79,8'h7a,8'h7b,8'h7c,8'h7d,8'h7e,8'h7f,8'h3d,
        8'h80,8'h81,8'h82,8'h83,8'h6c,8'h84,8'h85,8'h86,8'h70,8'h87},
      '{8'h00,8'h68,8'h69,8'h6a,8'h6c,8'h6e,8'h70,8'h72,8'h73,8'h74,
        8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h7b,8'h7c,8'h7e,8'h80},
      '{8'h00,8'h68,8'h69,8'h6b,8'h6d,8'h6f,8'h71,8'h72,8'h73,8'h74,
        8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h7b,8'h7d,8'h7f,8'h80},
      '{8'h00,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hbb,8'hbc,8'hbd,8'hbe,
        8'hbf,8'hc0,8'hc1,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8},
      '{8'h00,8'h8a,8'h8b,8'h8c,8'h8e,8'h90,8'h92,8'h94,8'h95,8'h96,
        8'h97,8'h98,8'h99,8'h9a,8'h9b,8'h9c,8'h9d,8'h9e,8'ha0,8'ha2},
      '{8'h00,8'h8a,8'h8b,8'h8d,8'h8f,8'h91,8'h93,8'h94,8'h95,8'h96,
        8'h97,8'h98,8'h99,8'h9a,8'h9b,8'h9c,8'h9d,8'h9f,8'ha1,8'ha2},
      '{8'h00,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hbb,8'hbc,8'hbd,8'h96,
        8'hbe,8'hbf,8'hc0,8'hc1,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7},
      '{8'h00,8'hdd,8'hde,8'hdf,8'he0,8'hba,8'he1,8'he2,8'he3,8'h96,
        8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hc5,8'hc6,8'heb}};

    localparam logic [3:0] INIT_ROW [2][22] = '{
      '{4'd0,4'd0,4'd0,4'd0,4'd0,4'd1,4'd1,4'd1,4'd1,4'd2,4'd4,4'd5,4'd4,4'd2,4'd3,4'd6,4'd7,
        4'd6,4'd3,4'd2,4'd4,4'd0},
      '{4'd0,4'd8,4'd11,4'd8,4'd11,4'd9,4'd12,4'd9,4'd12,4'd10,4'd13,4'd14,4'd13,4'd10,4'd10,
        4'd13,4'd14,4'd13,4'd10,4'd10,4'd13,4'd8}};

    localparam logic [7:0] FINAL_GLYPHS [5][28] = '{
      '{8'h00,8'h99,8'h9b,8'h9c,8'h9d,8'h9e,8'h9f,8'ha0,8'ha1,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
        8'hf1,8'ha8,8'ha9,8'haa,8'hab,8'hac,8'had,8'hae,8'hb0,8'hb1,8'hb2,8'hb3,8'hb4,8'hb5},
      '{8'h00,8'h9a,8'h9b,8'h9c,8'h9d,8'h9e,8'h9f,8'ha0,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
        8'hf1,8'ha8,8'ha9,8'haa,8'hab,8'hac,8'had,8'haf,8'hb0,8'hb1,8'hb2,8'hb3,8'hb4,8'hb5},
      '{8'h00,8'he4,8'he6,8'he7,8'he8,8'h9e,8'he9,8'hea,8'heb,8'hed,8'hee,8'ha5,8'hef,8'hf0,
        8'hf1,8'hf2,8'hf3,8'hf5,8'hab,8'hf6,8'had,8'hf7,8'hf9,8'hfa,8'hfb,8'hfc,8'hfe,8'hff},
      '{8'h00,8'he5,8'he6,8'he7,8'he8,8'h9e,8'he9,8'hea,8'hec,8'hed,8'hee,8'ha5,8'hef,8'hf0,
        8'hf1,8'hf2,8'hf4,8'hf5,8'hab,8'hf6,8'had,8'hf8,8'hf9,8'hfa,8'hfb,8'hfd,8'hfe,8'hff},
      '{8'h00,8'hf4,8'hf4,8'hf4,8'hf5,8'hf5,8'hf5,8'hf6,8'hf7,8'hf7,8'hf8,8'hf8,8'hf8,8'hf8,
        8'hf8,8'hf8,8'hf9,8'hfa,8'hfa,8'hfb,8'hfc,8'hfd,8'hfe,8'hfe,8'hfe,8'hff,8'hff,8'hff}};

    localparam logic [2:0] FINAL_CLASS [22] = '{3'd0,3'd0,3'd4,3'd0,3'd4,3'd0,3'd4,3'd0,3'd4,
        3'd2,3'd4,3'd4,3'd4,3'd2,3'd2,3'd4,3'd4,3'd4,3'd2,3'd2,3'd4,3'd0};

    function automatic logic in_set(input logic [4:0] v, input logic [31:0] mask);
        in_set = mask[v];
    endfunction

    function automatic logic [31:0] bm(input int b);
        bm = 32'd1 << b;
    endfunction

    function automatic logic [7:0] by_h(input logic [4:0] f, input logic [7:0] h,
                                       input logic [7:0] o);
        by_h = (f == IDX_H) ? h : o;
    endfunction

    function automatic logic [7:0] vowel_open(input logic [4:0] f, input logic [4:0] m);
        logic [7:0] r;
        case (m)
            5'd1: r = 8'h29;
            5'd2: r = in_set(f, DGRP) ? 8'h2a : 8'h29;
            5'd3: r = 8'h2a;
            5'd4: r = 8'h2b;
            5'd5:
                if (in_set(f, bm(3)|bm(4)|bm(10))) r = 8'h2c;
                else if (in_set(f, bm(9)|bm(11)|bm(14))) r = 8'h2d;
                else if (in_set(f, bm(15)|bm(19))) r = 8'h2e;
                else r = 8'h2b;
            5'd6:
                if (in_set(f, KGRP)) r = 8'h2c;
                else if (in_set(f, bm(3)|bm(4)|bm(10))) r = 8'h2d;
                else if (in_set(f, bm(5)|bm(9)|bm(11)|bm(14))) r = 8'h2f;
                else if (in_set(f, bm(15)|bm(19))) r = 8'h30;
                else r = 8'h2e;
            5'd7: r = in_set(f, bm(3)|bm(4)|bm(10)|bm(17)) ? 8'h30 : 8'h2f;
            5'd8:
                if (in_set(f, bm(1)|bm(2)|bm(8)|bm(15)|bm(16))) r = 8'h31;
                else if (in_set(f, bm(3)|bm(4)|bm(10))) r = 8'h32;
                else if (f == IDX_H) r = 8'h34;
                else r = 8'h33;
            5'd9:  r = (f == 5'd1) ? 8'h47 : by_h(f, 8'h49, 8'h48);
            5'd10: r = (f == 5'd1) ? 8'h48 : by_h(f, 8'h4a, 8'h49);
            5'd11: r = (f == 5'd1) ? 8'h5d : by_h(f, 8'h5f, 8'h5e);
            5'd12: r = (f == 5'd1) ? 8'h4b : by_h(f, 8'h4d, 8'h4c);
            5'd13: r = (f == 5'd1) ? 8'h4a : by_h(f, 8'h4c, 8'h4b);
            5'd14: r = in_set(f, KGRP) ? 8'h62 : by_h(f, 8'h64, 8'h63);
            5'd15: r = in_set(f, KGRP) ? 8'h72 : by_h(f, 8'h74, 8'h73);
            5'd16: r = in_set(f, KGRP) ? 8'h88 : 8'h89;
            5'd17: r = in_set(f, KGRP) ? 8'h75 : by_h(f, 8'h77, 8'h76);
            5'd18: r = in_set(f, KGRP) ? 8'h65 : by_h(f, 8'h67, 8'h66);
            5'd19: r = in_set(f, KGRP | bm(3)) ? 8'h4d : 8'h4e;
            5'd20: r = in_set(f, KGRP) ? 8'h4e : 8'h4f;
            5'd21: r = 8'h33;
            default: r = 8'h00;
        endcase
        vowel_open = r;
    endfunction

    function automatic logic [7:0] vowel_closed(input logic [4:0] f, input logic [4:0] m,
                                               input logic [4:0] l);
        logic       ln;
        logic [7:0] r;
        logic [7:0] lnv;
        ln  = (l == 5'd4) || (l == 5'd19);
        lnv = {7'd0, ln};
        case (m)
            5'd1: r = ln ? 8'h81 : 8'h82;
            5'd2:
                if (ln) r = in_set(f, DGRP) ? 8'ha6 : 8'ha4;
                else r = in_set(f, DGRP) ? 8'ha5 : 8'ha3;
            5'd3: r = ln ? 8'h83 : 8'h84;
            5'd4: r = ln ? 8'ha8 : 8'ha7;
            5'd5:
                if (in_set(f, KGRP)) r = 8'h85 + lnv;
                else if (in_set(f, bm(3)|bm(4)|bm(10))) r = 8'h87 + lnv;
                else if (in_set(f, bm(7)|bm(8)|bm(12)|bm(13))) r = 8'h89 + lnv;
                else if (in_set(f, bm(15)|bm(19))) r = 8'h8d + lnv;
                else r = 8'h8b + lnv;
            5'd6:
                if (in_set(f, bm(3)|bm(4)|bm(10))) r = 8'hab + lnv;
                else if (in_set(f, bm(5)|bm(9)|bm(11)|bm(14))) r = 8'had + lnv;
                else if (in_set(f, bm(15)|bm(19))) r = 8'haf + lnv;
                else r = 8'ha9 + lnv;
            5'd7:
                if (in_set(f, KGRP|bm(7)|bm(8)|bm(12))) r = 8'h8f + lnv;
                else if (in_set(f, bm(3)|bm(4)|bm(10))) r = 8'h91 + lnv;
                else if (in_set(f, bm(15)|bm(19))) r = 8'h95 + lnv;
                else r = 8'h93 + lnv;
            5'd8:
                if (in_set(f, bm(3)|bm(4))) r = ln ? 8'hb3 : 8'hb1;
                else if (in_set(f, bm(15)|bm(19))) r = ln ? 8'hb5 : 8'hb4;
                else r = ln ? 8'hb2 : 8'hb1;
            5'd9:
                if (f == 5'd1) r = 8'hc9;
                else if (in_set(f, bm(6)|bm(13)|bm(14)|bm(15)|bm(16))) r = 8'hcb;
                else if (in_set(f, bm(17)|bm(18)|bm(19))) r = 8'hcc;
                else r = 8'hca;
            5'd10: r = ln ? by_h(f, 8'hcc, 8'hca) : by_h(f, 8'hcb, 8'hc9);
            5'd11: r = ln ? by_h(f, 8'hef, 8'hed) : by_h(f, 8'hee, 8'hec);
            5'd12: r = ln ? by_h(f, 8'hd0, 8'hce) : by_h(f, 8'hcf, 8'hcd);
            5'd13:
                if (f == 5'd1) r = 8'hcd;
                else if (in_set(f, bm(6)|bm(12)|bm(14)|bm(15)|bm(17)|bm(18))) r = 8'hcf;
                else if (f == IDX_H) r = 8'hd0;
                else r = 8'hce;
            5'd14:
                if (in_set(f, KGRP))
                    r = (l == 5'd23 || l == 5'd27) ? 8'hd1 : ((l == 5'd4) ? 8'hd2 : 8'hd3);
                else if (f == IDX_H) r = (l == 5'd4) ? 8'hd4 : 8'hd5;
                else if (in_set(l, bm(1)|bm(7)|bm(16)|bm(17)|bm(20))) r = 8'hd6;
                else r = (l == 5'd4) ? 8'hd7 : 8'hd8;
            5'd15: r = ln ? by_h(f, 8'hd8, 8'hd6) : by_h(f, 8'hd7, 8'hd5);
            5'd16: r = ln ? by_h(f, 8'hf3, 8'hf1) : by_h(f, 8'hf2, 8'hf0);
            5'd17: r = ln ? by_h(f, 8'hdc, 8'hda) : by_h(f, 8'hdb, 8'hd9);
            5'd18:
                if (in_set(f, KGRP))
                    r = (l == 5'd23 || l == 5'd27) ? 8'hd9 : ((l == 5'd4) ? 8'hda : 8'hdb);
                else if (f == IDX_H) r = (l == 5'd4) ? 8'hdc : 8'hdd;
                else if (in_set(l, bm(1)|bm(7)|bm(16)|bm(17)|bm(19))) r = 8'hde;
                else r = (l == 5'd4) ? 8'hdf : 8'he0;
            5'd19: r = in_set(f, KGRP) ? 8'he1 : by_h(f, 8'he2, 8'he3);
            5'd20: r = ln ? by_h(f, 8'hd4, 8'hd2) : by_h(f, 8'hd3, 8'hd1);
            5'd21: r = ln ? 8'h97 : 8'h98;
            default: r = 8'h00;
        endcase
        vowel_closed = r;
    endfunction

    // indices are in range when this is called
    function automatic logic [7:0] final_glyph_of(input logic [4:0] f, input logic [4:0] m,
                                                 input logic [4:0] l);
        logic [7:0] r;
        case (FINAL_CLASS[m])
            3'd0:
                if (in_set(f, bm(1)|bm(3)|bm(4)|bm(5)|bm(7)|bm(10)|bm(13)|bm(16)))
                    r = FINAL_GLYPHS[0][l];
                else
                    r = FINAL_GLYPHS[1][l];
            3'd2: r = (f == IDX_H) ? FINAL_GLYPHS[3][l] : FINAL_GLYPHS[2][l];
            default: r = FINAL_GLYPHS[4][l];
        endcase
        final_glyph_of = r;
    endfunction

    function automatic out_item_t select_glyphs(input in_item_t it);
        out_item_t  o;
        logic [4:0] f;
        logic [4:0] m;
        logic [4:0] l;
        f = it.initial_index;
        m = it.vowel_index;
        l = it.final_index;
        o = '0;
        if (f > INIT_MAX || m > VOWEL_MAX || l > FINAL_MAX) begin
            o.font_set      = 2'd1;
            o.glyph_count   = CNT_TWO;
            o.index_invalid = 1'b1;
        end else begin
            o.font_set      = SET2_MASK[m] ? 2'd2 : 2'd1;
            o.initial_glyph = INIT_GLYPHS[INIT_ROW[l != 5'd0][m]][f];
            if (m == 5'd0 && l == 5'd0) begin
                o.glyph_count = CNT_THREE;
            end else if (l == 5'd0) begin
                o.vowel_glyph = vowel_open(f, m);
                o.glyph_count = CNT_TWO;
            end else begin
                o.vowel_glyph = vowel_closed(f, m, l);
                o.final_glyph = final_glyph_of(f, m, l);
                o.glyph_count = CNT_THREE;
            end
        end
        select_glyphs = o;
    endfunction

endpackage

// ===== sv/hangul_jamo_glyph_selector.sv =====
// Top level of the Hangul syllable glyph selector
//
// Usage:
//   in channel  : in_valid / in_ready / in_data carries one syllable item
//                 (initial, vowel and final jamo indices).
//   out channel : out_valid / out_ready / out_data carries one glyph item
//                 (font set, three glyph codes, glyph count, invalid flag).
//   Each accepted item yields exactly one result item, in order.
//   Path: an accepted item is held in the input register, then the table
//   lookup writes its glyphs into the result register.
//   Throughput: one item per cycle while out_ready stays high; a stall
//   holds the flow as described below.
//   Stall: when out_ready is low the result register holds; the input stage
//   still takes one more item if it is empty, after which in_ready drops until
//   the result moves on.
//   Reset: rst_n clears both valid flags; no item is pending afterwards.
//   There is no configuration and no state kept between items.
`include "hangul_jamo_glyph_selector_macros.svh"
module hangul_jamo_glyph_selector (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hjgs_pkg::in_item_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output hjgs_pkg::out_item_t out_data
);

    hjgs_pkg::in_item_t  in_reg;
    logic                in_vld_reg;
    hjgs_pkg::out_item_t res_reg;
    logic                res_vld_reg;
    logic                res_load;

    // advance the result register when empty or being drained
    assign res_load = !res_vld_reg || out_ready;
    assign in_ready = !in_vld_reg || res_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (res_load)
                res_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_reg <= in_data;
        if (res_load && in_vld_reg)
            res_reg <= hjgs_pkg::select_glyphs(in_reg);
    end

    assign out_valid = res_vld_reg;
    assign out_data  = res_reg;

    `HJGS_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_data), "result changed while stalled")
    `HJGS_ASSERT_NEXT(a_stage_moves, clk, rst_n, in_vld_reg && res_load, res_vld_reg,
        "held item was lost")
    `HJGS_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_valid && out_data.index_invalid,
        out_data.initial_glyph == 8'd0 && out_data.glyph_count == hjgs_pkg::CNT_TWO,
        "invalid item carries glyphs")
    `HJGS_ASSERT_NOW(a_count_range, clk, rst_n, out_valid,
        out_data.glyph_count == hjgs_pkg::CNT_TWO || out_data.glyph_count == hjgs_pkg::CNT_THREE,
        "bad glyph count")

endmodule

// ===== dv/tb_hangul_jamo_glyph_selector.sv =====
// Self-checking testbench for the Hangul syllable glyph selector
module tb_hangul_jamo_glyph_selector;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    hjgs_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    hjgs_pkg::out_item_t out_data;

    // syllables waiting to be offered, and glyph sets expected back
    hjgs_pkg::in_item_t  syllable_q[$];
    hjgs_pkg::out_item_t glyph_q[$];

    int  mismatch_count;
    int  sent_count;
    bit  stim_done;
    bit  calm_phase;      // no idling in the closing stretch
    int  send_gap;
    int  recv_gap;
    int  hold_off;        // long receiver stall, counted down in its own process
    bit  hold_done;

    hangul_jamo_glyph_selector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    // membership test of an index in a bit set
    function automatic bit has(input logic [4:0] v, input logic [31:0] set);
        return set[v];
    endfunction

    // glyph for the vowel when the syllable has no final
    function automatic logic [7:0] open_vowel_glyph(input logic [4:0] f, input logic [4:0] m);
        logic [31:0] kset;
        logic [31:0] dset;
        bit          is_h;
        kset = 32'h0001_0006;
        dset = 32'h0000_4A24;
        is_h = (f == 5'd19);
        case (m)
            5'd1:  return 8'h29;
            5'd2:  return has(f, dset) ? 8'h2a : 8'h29;
            5'd3:  return 8'h2a;
            5'd4:  return 8'h2b;
            5'd5:
                if (has(f, 32'h0000_0418)) return 8'h2c;
                else if (has(f, 32'h0000_4A00)) return 8'h2d;
                else if (has(f, 32'h0008_8000)) return 8'h2e;
                else return 8'h2b;
            5'd6:
                if (has(f, kset)) return 8'h2c;
                else if (has(f, 32'h0000_0418)) return 8'h2d;
                else if (has(f, 32'h0000_4A20)) return 8'h2f;
                else if (has(f, 32'h0008_8000)) return 8'h30;
                else return 8'h2e;
            5'd7:  return has(f, 32'h0002_0418) ? 8'h30 : 8'h2f;
            5'd8:
                if (has(f, 32'h0001_8106)) return 8'h31;
                else if (has(f, 32'h0000_0418)) return 8'h32;
                else if (is_h) return 8'h34;
                else return 8'h33;
            5'd9:  return f == 5'd1 ? 8'h47 : (is_h ? 8'h49 : 8'h48);
            5'd10: return f == 5'd1 ? 8'h48 : (is_h ? 8'h4a : 8'h49);
            5'd11: return f == 5'd1 ? 8'h5d : (is_h ? 8'h5f : 8'h5e);
            5'd12: return f == 5'd1 ? 8'h4b : (is_h ? 8'h4d : 8'h4c);
            5'd13: return f == 5'd1 ? 8'h4a : (is_h ? 8'h4c : 8'h4b);
            5'd14: return has(f, kset) ? 8'h62 : (is_h ? 8'h64 : 8'h63);
            5'd15: return has(f, kset) ? 8'h72 : (is_h ? 8'h74 : 8'h73);
            5'd16: return has(f, kset) ? 8'h88 : 8'h89;
            5'd17: return has(f, kset) ? 8'h75 : (is_h ? 8'h77 : 8'h76);
            5'd18: return has(f, kset) ? 8'h65 : (is_h ? 8'h67 : 8'h66);
            5'd19: return has(f, kset | 32'h8) ? 8'h4d : 8'h4e;
            5'd20: return has(f, kset) ? 8'h4e : 8'h4f;
            5'd21: return 8'h33;
            default: return 8'h00;
        endcase
    endfunction

    // glyph for the vowel when a final follows
    function automatic logic [7:0] closed_vowel_glyph(input logic [4:0] f, input logic [4:0] m,
                                                      input logic [4:0] l);
        logic [31:0] kset;
        logic [31:0] dset;
        bit          is_h;
        logic [7:0]  n;
        kset = 32'h0001_0006;
        dset = 32'h0000_4A24;
        is_h = (f == 5'd19);
        n    = (l == 5'd4 || l == 5'd19) ? 8'd1 : 8'd0;
        case (m)
            5'd1:  return n ? 8'h81 : 8'h82;
            5'd2:  return n ? (has(f, dset) ? 8'ha6 : 8'ha4) : (has(f, dset) ? 8'ha5 : 8'ha3);
            5'd3:  return n ? 8'h83 : 8'h84;
            5'd4:  return n ? 8'ha8 : 8'ha7;
            5'd5:
                if (has(f, kset)) return 8'h85 + n;
                else if (has(f, 32'h0000_0418)) return 8'h87 + n;
                else if (has(f, 32'h0000_3180)) return 8'h89 + n;
                else if (has(f, 32'h0008_8000)) return 8'h8d + n;
                else return 8'h8b + n;
            5'd6:
                if (has(f, 32'h0000_0418)) return 8'hab + n;
                else if (has(f, 32'h0000_4A20)) return 8'had + n;
                else if (has(f, 32'h0008_8000)) return 8'haf + n;
                else return 8'ha9 + n;
            5'd7:
                if (has(f, kset | 32'h0000_1180)) return 8'h8f + n;
                else if (has(f, 32'h0000_0418)) return 8'h91 + n;
                else if (has(f, 32'h0008_8000)) return 8'h95 + n;
                else return 8'h93 + n;
            5'd8:
                if (has(f, 32'h0000_0018)) return n ? 8'hb3 : 8'hb1;
                else if (has(f, 32'h0008_8000)) return n ? 8'hb5 : 8'hb4;
                else return n ? 8'hb2 : 8'hb1;
            5'd9:
                if (f == 5'd1) return 8'hc9;
                else if (has(f, 32'h0001_E040)) return 8'hcb;
                else if (has(f, 32'h000E_0000)) return 8'hcc;
                else return 8'hca;
            5'd10: return n ? (is_h ? 8'hcc : 8'hca) : (is_h ? 8'hcb : 8'hc9);
            5'd11: return n ? (is_h ? 8'hef : 8'hed) : (is_h ? 8'hee : 8'hec);
            5'd12: return n ? (is_h ? 8'hd0 : 8'hce) : (is_h ? 8'hcf : 8'hcd);
            5'd13:
                if (f == 5'd1) return 8'hcd;
                else if (has(f, 32'h0006_D040)) return 8'hcf;
                else if (is_h) return 8'hd0;
                else return 8'hce;
            5'd14:
                if (has(f, kset))
                    return (l == 5'd23 || l == 5'd27) ? 8'hd1 : (l == 5'd4 ? 8'hd2 : 8'hd3);
                else if (is_h) return l == 5'd4 ? 8'hd4 : 8'hd5;
                else if (has(l, 32'h0013_0082)) return 8'hd6;
                else return l == 5'd4 ? 8'hd7 : 8'hd8;
            5'd15: return n ? (is_h ? 8'hd8 : 8'hd6) : (is_h ? 8'hd7 : 8'hd5);
            5'd16: return n ? (is_h ? 8'hf3 : 8'hf1) : (is_h ? 8'hf2 : 8'hf0);
            5'd17: return n ? (is_h ? 8'hdc : 8'hda) : (is_h ? 8'hdb : 8'hd9);
            5'd18:
                if (has(f, kset))
                    return (l == 5'd23 || l == 5'd27) ? 8'hd9 : (l == 5'd4 ? 8'hda : 8'hdb);
                else if (is_h) return l == 5'd4 ? 8'hdc : 8'hdd;
                else if (has(l, 32'h000B_0082)) return 8'hde;
                else return l == 5'd4 ? 8'hdf : 8'he0;
            5'd19: return has(f, kset) ? 8'he1 : (is_h ? 8'he2 : 8'he3);
            5'd20: return n ? (is_h ? 8'hd4 : 8'hd2) : (is_h ? 8'hd3 : 8'hd1);
            5'd21: return n ? 8'h97 : 8'h98;
            default: return 8'h00;
        endcase
    endfunction

    // predict the glyph set for one syllable
    function automatic hjgs_pkg::out_item_t predict_glyphs(input hjgs_pkg::in_item_t s);
        hjgs_pkg::out_item_t g;
        logic [4:0]  f;
        logic [4:0]  m;
        logic [4:0]  l;
        int          row;
        int          fc;
        f = s.initial_index;
        m = s.vowel_index;
        l = s.final_index;
        g = '0;
        g.glyph_count = hjgs_pkg::CNT_TWO;
        g.font_set    = 2'd1;
        if (f > 5'd19 || m > 5'd21 || l > 5'd27) begin
            g.index_invalid = 1'b1;
            return g;
        end
        // font set 2 for the vowels drawn in the wider composite set
        if (has(m, 32'h0013_9D54)) g.font_set = 2'd2;
        row = hjgs_pkg::INIT_ROW[l != 5'd0][m];
        g.initial_glyph = hjgs_pkg::INIT_GLYPHS[row][f];
        if (m == 5'd0 && l == 5'd0) begin
            g.glyph_count = hjgs_pkg::CNT_THREE;
        end else if (l == 5'd0) begin
            g.vowel_glyph = open_vowel_glyph(f, m);
        end else begin
            g.vowel_glyph = closed_vowel_glyph(f, m, l);
            g.glyph_count = hjgs_pkg::CNT_THREE;
            fc = hjgs_pkg::FINAL_CLASS[m];
            if (fc == 0)
                g.final_glyph = has(f, 32'h0001_24BA) ? hjgs_pkg::FINAL_GLYPHS[0][l]
                                                      : hjgs_pkg::FINAL_GLYPHS[1][l];
            else if (fc == 2)
                g.final_glyph = (f == 5'd19) ? hjgs_pkg::FINAL_GLYPHS[3][l]
                                             : hjgs_pkg::FINAL_GLYPHS[2][l];
            else
                g.final_glyph = hjgs_pkg::FINAL_GLYPHS[4][l];
        end
        return g;
    endfunction

    function automatic hjgs_pkg::in_item_t make_syllable(input int f, input int m, input int l);
        hjgs_pkg::in_item_t s;
        s.initial_index = f[4:0];
        s.vowel_index   = m[4:0];
        s.final_index   = l[4:0];
        return s;
    endfunction

    // Driver: offer the head of the queue, hold it until accepted, idle in bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end else begin
            if (in_valid && in_ready) begin
                glyph_q.push_back(predict_glyphs(in_data));
                sent_count = sent_count + 1;
            end
            if (in_valid && !in_ready) begin
                // hold the item
            end else if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
                in_valid <= 1'b0;
                send_gap <= $urandom_range(0, 4);
            end else if (syllable_q.size() > 0) begin
                in_valid <= 1'b1;
                in_data  <= syllable_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        hjgs_pkg::out_item_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (glyph_q.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h", out_data);
                end else begin
                    want = glyph_q.pop_front();
                    if (out_data.font_set !== want.font_set ||
                        out_data.initial_glyph !== want.initial_glyph ||
                        out_data.vowel_glyph !== want.vowel_glyph ||
                        out_data.final_glyph !== want.final_glyph ||
                        out_data.glyph_count !== want.glyph_count ||
                        out_data.index_invalid !== want.index_invalid) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %h actual %h", want, out_data);
                    end
                end
            end
            if (hold_off > 0) begin
                out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                out_ready <= 1'b0;
                recv_gap  <= recv_gap - 1;
            end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
                out_ready <= 1'b0;
                recv_gap  <= $urandom_range(0, 4);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Long receiver stall once, midway, so the block backs up and drops in_ready.
    always @(posedge clk)
    begin
        if (rst_n && !hold_done && sent_count >= 300) begin
            hold_off  <= 60;
            hold_done <= 1'b1;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    initial
    begin
        int wait_cycles;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        hold_off = 0;
        hold_done = 1'b0;
        calm_phase = 1'b0;
        stim_done = 1'b0;
        mismatch_count = 0;
        sent_count = 0;

        // directed: empty syllable, extremes, special cases, every odd vowel
        syllable_q.push_back(make_syllable(0, 0, 0));
        syllable_q.push_back(make_syllable(19, 21, 27));
        syllable_q.push_back(make_syllable(1, 0, 0));
        syllable_q.push_back(make_syllable(5, 9, 0));
        syllable_q.push_back(make_syllable(19, 0, 4));
        syllable_q.push_back(make_syllable(20, 1, 1));
        syllable_q.push_back(make_syllable(0, 22, 0));
        syllable_q.push_back(make_syllable(0, 0, 28));
        syllable_q.push_back(make_syllable(31, 31, 31));
        syllable_q.push_back(make_syllable(2, 14, 23));
        syllable_q.push_back(make_syllable(7, 18, 19));
        for (int m = 1; m <= 21; m += 2)
            syllable_q.push_back(make_syllable(m % 20, m, (m * 3) % 28));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // random: mostly valid indices, a share of any 5-bit value
        for (int i = 0; i < 1000; i++) begin
            if ($urandom_range(0, 9) == 0)
                syllable_q.push_back(make_syllable($urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 31)));
            else
                syllable_q.push_back(make_syllable($urandom_range(0, 19),
                    $urandom_range(0, 21), $urandom_range(0, 1) ? $urandom_range(0, 27) : 0));
            if (i == 850) begin
                while (syllable_q.size() > 150) @(posedge clk);
                calm_phase = 1'b1;
            end
        end

        wait_cycles = 0;
        while ((syllable_q.size() > 0 || in_valid || glyph_q.size() > 0)
               && wait_cycles < 100000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (5) @(posedge clk);
        if (mismatch_count == 0 && glyph_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
